@@ sv/tc_pkg.sv @@
// tc_pkg: shared types, constants and helper functions for the token canonicalizer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tc_pkg;

   // Output length cap, counting a held dot.
   localparam int unsigned MAX_LEN = 128;
   localparam int unsigned LEN_W   = $clog2(MAX_LEN + 1);

   localparam int unsigned FALLBACK_LEN = 7;
   localparam int unsigned STEP_W       = $clog2(FALLBACK_LEN);

   localparam logic [7:0] CH_DOT  = 8'h2E;
   localparam logic [7:0] CH_NUL  = 8'h00;
   localparam logic [7:0] CH_UP_A = 8'h41;
   localparam logic [7:0] CH_UP_Z = 8'h5A;
   localparam logic [7:0] CH_LO_A = 8'h61;
   localparam logic [7:0] CH_LO_Z = 8'h7A;
   localparam logic [7:0] CH_D0   = 8'h30;
   localparam logic [7:0] CH_D9   = 8'h39;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // Input operation codes.
   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_END  = 1'b1
   } op_type;

   // What one accepted item hands to the output serializer.
   typedef enum logic [1:0] {
      BURST_CHAR     = 2'd0,  // one character
      BURST_DOT_CHAR = 2'd1,  // held dot, then one character
      BURST_UNNAMED  = 2'd2,  // fallback name
      BURST_TERM     = 2'd3   // empty terminator
   } burst_kind_type;

   typedef struct packed {
      logic           valid;
      burst_kind_type kind;
      logic [7:0]     ch;
   } burst_type;

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CH_UP_A && c <= CH_UP_Z) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_D0 && c <= CH_D9);
   endfunction

   // Characters of the fallback name "unnamed".
   function automatic logic [7:0] fallback_char(input logic [STEP_W-1:0] idx);
      logic [7:0] r;
      case (idx)
         3'd0: r = 8'h75;  // u
         3'd1: r = 8'h6E;  // n
         3'd2: r = 8'h6E;  // n
         3'd3: r = 8'h61;  // a
         3'd4: r = 8'h6D;  // m
         3'd5: r = 8'h65;  // e
         3'd6: r = 8'h64;  // d
         default: r = CH_NUL;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

@@ sv/tc_chan_if.sv @@
// tc_chan_if: valid/ready channel interfaces for requests and responses.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface tc_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] text_byte;

   modport source (output valid, output op, output text_byte, input ready);
   modport sink   (input valid, input op, input text_byte, output ready);
endinterface

interface tc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       has_char;
   logic       last;

   modport source (output valid, output out_byte, output has_char, output last,
                   input ready);
   modport sink   (input valid, input out_byte, input has_char, input last,
                   output ready);
endinterface

`default_nettype wire

@@ sv/tc_decode.sv @@
// tc_decode: classifies request bytes, keeps token state, registers one burst.
// Depends on tc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tc_decode (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire logic              req_op,
   input  wire logic [7:0]        req_text_byte,
   input  wire logic              burst_consume,
   output      tc_pkg::burst_type burst
);
   import tc_pkg::*;

   logic [LEN_W-1:0] length_used_ff, length_used_in;
   logic             dot_pending_ff, dot_pending_in;
   logic             after_sep_ff, after_sep_in;
   burst_type        burst_ff, burst_in;

   logic       accept;
   logic [7:0] lower;

   assign req_ready = !burst_ff.valid || burst_consume;
   assign accept    = req_valid && req_ready;
   assign lower     = to_lower(req_text_byte);

   always_comb begin
      length_used_in = length_used_ff;
      dot_pending_in = dot_pending_ff;
      after_sep_in   = after_sep_ff;
      burst_in       = burst_ff;
      if (burst_consume) begin
         burst_in.valid = 1'b0;
      end
      if (accept) begin
         if (op_type'(req_op) == OP_END) begin
            burst_in.valid = 1'b1;
            burst_in.kind  = (length_used_ff == '0) ? BURST_UNNAMED : BURST_TERM;
            burst_in.ch    = CH_NUL;
            length_used_in = '0;
            dot_pending_in = 1'b0;
            after_sep_in   = 1'b1;
         end else if (length_used_ff < LEN_W'(MAX_LEN)) begin
            if (is_alnum(lower)) begin
               burst_in.valid = 1'b1;
               burst_in.kind  = dot_pending_ff ? BURST_DOT_CHAR : BURST_CHAR;
               burst_in.ch    = lower;
               length_used_in = length_used_ff + LEN_W'(1);
               dot_pending_in = 1'b0;
               after_sep_in   = 1'b0;
            end else if (!after_sep_ff) begin
               length_used_in = length_used_ff + LEN_W'(1);
               dot_pending_in = 1'b1;
               after_sep_in   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_used_ff <= '0;
         dot_pending_ff <= 1'b0;
         after_sep_ff   <= 1'b1;
         burst_ff.valid <= 1'b0;
      end else begin
         length_used_ff <= length_used_in;
         dot_pending_ff <= dot_pending_in;
         after_sep_ff   <= after_sep_in;
         burst_ff.valid <= burst_in.valid;
      end
      burst_ff.kind <= burst_in.kind;
      burst_ff.ch   <= burst_in.ch;
   end

   assign burst = burst_ff;

endmodule

`default_nettype wire

@@ sv/tc_emit.sv @@
// tc_emit: walks a registered burst one response per unstalled cycle into the output register.
// Depends on tc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tc_emit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tc_pkg::burst_type burst,
   output      logic              burst_consume,
   output      logic              rsp_valid,
   input  wire logic              rsp_ready,
   output      logic [7:0]        rsp_out_byte,
   output      logic              rsp_has_char,
   output      logic              rsp_last
);
   import tc_pkg::*;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              has_char_ff, has_char_in;
   logic              last_ff, last_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic load;
   logic final_step;

   assign load = burst.valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      out_byte_in = burst.ch;
      has_char_in = 1'b1;
      last_in     = 1'b0;
      final_step  = 1'b1;
      case (burst.kind)
         BURST_CHAR: begin
         end
         BURST_DOT_CHAR: begin
            final_step = (step_ff != '0);
            if (step_ff == '0) begin
               out_byte_in = CH_DOT;
            end
         end
         BURST_UNNAMED: begin
            final_step  = (step_ff == STEP_W'(FALLBACK_LEN - 1));
            out_byte_in = fallback_char(step_ff);
            last_in     = final_step;
         end
         BURST_TERM: begin
            out_byte_in = CH_NUL;
            has_char_in = 1'b0;
            last_in     = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign burst_consume = load && final_step;
   assign rsp_valid_in  = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   assign step_in       = load ? (final_step ? '0 : step_ff + STEP_W'(1)) : step_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
      end
      if (load) begin
         out_byte_ff <= out_byte_in;
         has_char_ff <= has_char_in;
         last_ff     <= last_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_has_char = has_char_ff;
   assign rsp_last     = last_ff;

endmodule

`default_nettype wire

@@ sv/token_canonicalizer.sv @@
// token_canonicalizer: top level, byte stream in, canonical token characters out.
// Depends on tc_pkg, tc_chan_if, tc_decode, tc_emit.
//
//   channel   dir  fields                        accepted when
//   req_if    in   op, text_byte                 valid && ready
//   rsp_if    out  out_byte, has_char, last      valid && ready
//
// A request transaction is classified in the cycle it is accepted; its
// responses (a burst) are held in one register and walked out one per cycle,
// unless rsp_if stalls, into the response register. A plain character gives
// one response, a held dot plus character two, the fallback name seven, the
// empty terminator one; byte transactions that emit nothing never occupy the
// burst register. req_if.ready is high when the burst register is free or its
// last response is being loaded, so a new transaction follows the previous
// burst without a gap while the response register still waits on rsp_if.
// Reset is synchronous, active high, and empties both registers.
`timescale 1ns / 1ps
`default_nettype none

module token_canonicalizer (
   input wire logic clock,
   input wire logic reset,
   tc_req_if.sink   req_if,
   tc_rsp_if.source rsp_if
);
   import tc_pkg::*;

   burst_type burst;
   logic      burst_consume;

   // Classification and token state (length, held dot, separator run).
   tc_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_if.valid),
      .req_ready     (req_if.ready),
      .req_op        (req_if.op),
      .req_text_byte (req_if.text_byte),
      .burst_consume (burst_consume),
      .burst         (burst)
   );

   // Burst serializer and response register.
   tc_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .burst         (burst),
      .burst_consume (burst_consume),
      .rsp_valid     (rsp_if.valid),
      .rsp_ready     (rsp_if.ready),
      .rsp_out_byte  (rsp_if.out_byte),
      .rsp_has_char  (rsp_if.has_char),
      .rsp_last      (rsp_if.last)
   );

   // An empty response is always the terminator.
   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.has_char |-> rsp_if.last)
      else $error("empty response without last");

   // Characters out are lower case, digits or the dot.
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.has_char |->
         (rsp_if.out_byte >= CH_LO_A && rsp_if.out_byte <= CH_LO_Z) ||
         (rsp_if.out_byte >= CH_D0 && rsp_if.out_byte <= CH_D9) ||
         (rsp_if.out_byte == CH_DOT))
      else $error("response character outside canonical set");

   // A dot is never the final response of a token.
   a_no_dot_last: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.has_char && rsp_if.out_byte == CH_DOT |-> !rsp_if.last)
      else $error("dot flagged last");

   // Reset leaves no response pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_if.valid)
      else $error("response valid after reset");

endmodule

`default_nettype wire

@@ dv/token_canonicalizer_test.sv @@
// token_canonicalizer_test: self-checking bench for the token canonicalizer; a behavioral
// predictor checks every response transaction. Depends on tc_pkg, tc_chan_if and the RTL.
`timescale 1ns / 1ps

module token_canonicalizer_test;
   import tc_pkg::*;

   // Run control. The limit is far above the slowest legal run: about two hundred
   // requests, up to 7 responses each, 88% receiver stalls and one long hold-off.
   localparam int unsigned CYCLE_LIMIT  = 250000;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned PHASE_ITEMS  = 8;
   localparam int unsigned HOLD_ITEMS   = 12;

   localparam string FALLBACK_NAME = "unnamed";
   // Separator bytes the random part favors; anything non-alnum acts the same.
   localparam string SEPARATORS    = "._:- /,";

   // One response transaction as the checker sees it.
   typedef struct packed {
      logic [7:0] ch;
      logic       has_char;
      logic       last;
   } token_char_type;

   // Directed stimulus row. When spelled is set, the expected output is the
   // string in want: plain characters for a byte, and for an end of text the
   // same with last on the final one (an empty string means the terminator).
   typedef struct {
      op_type     op;
      logic [7:0] data;
      bit         spelled;
      string      want;
   } stim_row_type;

   logic clock;
   logic reset;

   tc_req_if req_ch ();
   tc_rsp_if rsp_ch ();

   token_canonicalizer dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Side-band that travels with each request transaction, so the monitor
   // knows whether a spelled-out expectation replaces the predictor's.
   bit    item_spelled;
   string item_want;

   // Idle knobs, percent per cycle; the hold-off is requested by a toggle.
   int unsigned src_idle_pct;
   int unsigned sink_stall_pct;
   bit          hold_kick;

   // Expected responses, oldest first, and the predictor's output for one step.
   token_char_type pending_rsp [$];
   token_char_type step_out [$];

   // Predictor state: characters used (held dot included), held dot, and
   // whether the last accepted byte was a separator or the token just began.
   logic [7:0] token_len    = '0;
   bit         dot_held     = 1'b0;
   bit         at_separator = 1'b1;

   int unsigned fail_count;
   int unsigned items_in;
   int unsigned results_seen;
   int unsigned tokens_closed;
   int unsigned capped_bytes;
   int unsigned cycle_count;

   stim_row_type directed [25] = '{
      '{OP_END,  8'hFF, 1'b1, "unnamed"},  // end right after reset, byte ignored
      '{OP_BYTE, 8'h2E, 1'b1, ""},         // '.' leading separator, dropped
      '{OP_BYTE, 8'hFF, 1'b1, ""},         // high byte, still leading
      '{OP_BYTE, 8'h41, 1'b1, "a"},        // 'A'
      '{OP_BYTE, 8'h5A, 1'b1, "z"},        // 'Z'
      '{OP_BYTE, 8'h5F, 1'b1, ""},         // '_' starts a held dot
      '{OP_BYTE, 8'h3A, 1'b1, ""},         // ':' same run, one dot only
      '{OP_BYTE, 8'h30, 1'b1, ".0"},       // '0' releases the dot
      '{OP_BYTE, 8'h39, 1'b1, "9"},        // '9'
      '{OP_BYTE, 8'h80, 1'b1, ""},         // lowest high byte
      '{OP_BYTE, 8'h61, 1'b1, ".a"},       // 'a'
      '{OP_BYTE, 8'h7A, 1'b1, "z"},        // 'z'
      '{OP_BYTE, 8'h2D, 1'b1, ""},         // trailing '-'
      '{OP_END,  8'h00, 1'b1, ""},         // terminator, held dot discarded
      '{OP_BYTE, 8'h00, 1'b1, ""},         // NUL
      '{OP_BYTE, 8'h40, 1'b1, ""},         // '@' just below 'A'
      '{OP_BYTE, 8'h5B, 1'b1, ""},         // '[' just above 'Z'
      '{OP_BYTE, 8'h60, 1'b1, ""},         // '`' just below 'a'
      '{OP_BYTE, 8'h7B, 1'b1, ""},         // '{' just above 'z'
      '{OP_BYTE, 8'h2F, 1'b1, ""},         // '/' just below '0'
      '{OP_END,  8'h55, 1'b1, "unnamed"},  // only separators seen
      '{OP_BYTE, 8'h4D, 1'b0, ""},         // 'M'
      '{OP_BYTE, 8'h20, 1'b0, ""},         // space
      '{OP_BYTE, 8'h37, 1'b0, ""},         // '7'
      '{OP_END,  8'hAA, 1'b0, ""}
   };

   // Queue tails: one response added to the step output or to the expected list.
   function automatic void add_step_rsp(input token_char_type r);
      step_out.insert(step_out.size(), r);
   endfunction

   function automatic void add_pending_rsp(input token_char_type r);
      pending_rsp.insert(pending_rsp.size(), r);
   endfunction

   // Behavioral predictor: one request transaction in, its responses in step_out.
   function automatic void canonicalize(input op_type op, input logic [7:0] data);
      logic [7:0] c;
      step_out.delete();
      if (op == OP_END) begin
         if (token_len == 0) begin
            for (int i = 0; i < FALLBACK_NAME.len(); i++) begin
               add_step_rsp(token_char_type'{FALLBACK_NAME[i], 1'b1,
                                             i == FALLBACK_NAME.len() - 1});
            end
         end else begin
            add_step_rsp(token_char_type'{CH_NUL, 1'b0, 1'b1});
         end
         token_len    = '0;
         dot_held     = 1'b0;
         at_separator = 1'b1;
         tokens_closed++;
      end else if (token_len >= MAX_LEN) begin
         // cap reached: byte ignored, state untouched
         capped_bytes++;
      end else begin
         c = data;
         if (c >= CH_UP_A && c <= CH_UP_Z) begin
            c = c - CH_UP_A + CH_LO_A;
         end
         if ((c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_D0 && c <= CH_D9)) begin
            if (dot_held) begin
               add_step_rsp(token_char_type'{CH_DOT, 1'b1, 1'b0});
            end
            add_step_rsp(token_char_type'{c, 1'b1, 1'b0});
            dot_held     = 1'b0;
            token_len    = token_len + 1'b1;
            at_separator = 1'b0;
         end else if (!at_separator) begin
            // first separator after a character: hold a dot, it counts now
            dot_held     = 1'b1;
            token_len    = token_len + 1'b1;
            at_separator = 1'b1;
         end
      end
   endfunction

   // Expectation written out by hand in a directed row.
   function automatic void spell_out(input op_type op, input string want);
      for (int i = 0; i < want.len(); i++) begin
         add_pending_rsp(token_char_type'{want[i], 1'b1,
                                          op == OP_END && i == want.len() - 1});
      end
      if (op == OP_END && want.len() == 0) begin
         add_pending_rsp(token_char_type'{CH_NUL, 1'b0, 1'b1});
      end
   endfunction

   function automatic logic [7:0] pick_alnum();
      logic [7:0] c;
      case ($urandom_range(0, 2))
         0:       c = CH_UP_A + 8'($urandom_range(0, 25));
         1:       c = CH_LO_A + 8'($urandom_range(0, 25));
         default: c = CH_D0 + 8'($urandom_range(0, 9));
      endcase
      return c;
   endfunction

   // Mostly text-like bytes, with a share of arbitrary ones as noise.
   function automatic logic [7:0] pick_byte();
      logic [7:0] c;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: c = pick_alnum();
         5, 6:          c = SEPARATORS[$urandom_range(0, SEPARATORS.len() - 1)];
         7:             c = 8'($urandom_range(128, 255));
         default:       c = 8'($urandom_range(0, 255));
      endcase
      return c;
   endfunction

   // Clock, 4 ns period.
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit, counted in cycles.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles, %0d responses still expected",
               $time, cycle_count, pending_rsp.size());
      $display("Regression FAIL");
      $finish;
   end

   // Receiver: random stalls per sink_stall_pct, plus a long hold-off whenever
   // hold_kick toggles; the hold-off is counted here, not by the sender.
   initial begin
      int unsigned hold_left;
      bit          hold_seen;
      hold_left = 0;
      hold_seen = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_kick != hold_seen) begin
            hold_seen = hold_kick;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
         end
      end
   end

   // Monitor. Responses are checked before requests are predicted: a response
   // accepted at this edge always belongs to an earlier request transaction.
   always @(posedge clock) begin
      token_char_type want_rsp;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected response: expected none, got byte %h has_char %b last %b",
                        $time, rsp_ch.out_byte, rsp_ch.has_char, rsp_ch.last);
               fail_count++;
            end else begin
               want_rsp = pending_rsp.pop_front();
               if (rsp_ch.out_byte !== want_rsp.ch) begin
                  $display("%0t: out_byte mismatch: expected %h, got %h",
                           $time, want_rsp.ch, rsp_ch.out_byte);
                  fail_count++;
               end
               if (rsp_ch.has_char !== want_rsp.has_char) begin
                  $display("%0t: has_char mismatch: expected %b, got %b",
                           $time, want_rsp.has_char, rsp_ch.has_char);
                  fail_count++;
               end
               if (rsp_ch.last !== want_rsp.last) begin
                  $display("%0t: last mismatch: expected %b, got %b",
                           $time, want_rsp.last, rsp_ch.last);
                  fail_count++;
               end
               results_seen++;
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            items_in++;
            // predictor always runs so its state tracks the block
            canonicalize(op_type'(req_ch.op), req_ch.text_byte);
            if (item_spelled) begin
               spell_out(op_type'(req_ch.op), item_want);
            end else begin
               foreach (step_out[i]) add_pending_rsp(step_out[i]);
            end
         end
      end
   end

   // Offer one request transaction and return at the edge that accepts it.
   // Called at a rising edge; valid is only dropped while the sender idles.
   task automatic send_item(input op_type op, input logic [7:0] data,
                            input bit spelled = 1'b0, input string want = "");
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.op        <= op;
      req_ch.text_byte <= data;
      item_spelled     <= spelled;
      item_want        <= want;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   // Sender pause until every expected response has come back. The queue is
   // polled on the falling edge, away from the monitor's updates.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(negedge clock);
      while (pending_rsp.size() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   // Random tokens of 0..9 bytes, each closed by an end of text. A zero-length
   // token gives back-to-back ends and the fallback name.
   task automatic random_tokens(input int unsigned budget);
      int unsigned sent;
      int unsigned len;
      sent = 0;
      while (sent < budget) begin
         len = $urandom_range(0, 9);
         repeat (len) send_item(OP_BYTE, pick_byte());
         send_item(OP_END, 8'($urandom_range(0, 255)));
         sent += len + 1;
      end
   endtask

   // Sender idle is read by this thread only, so it takes effect at once.
   task automatic run_phase(input int unsigned src_pct, input int unsigned snk_pct);
      src_idle_pct    = src_pct;
      sink_stall_pct <= snk_pct;
      random_tokens(PHASE_ITEMS);
   endtask

   // Token that runs into the length cap. With dot_at_cap, the held dot is what
   // fills the last slot, so the following character is ignored and the dot
   // is never emitted.
   task automatic cap_token(input bit dot_at_cap);
      int unsigned n;
      n = dot_at_cap ? MAX_LEN - 1 : MAX_LEN + 3;
      repeat (n) send_item(OP_BYTE, pick_alnum());
      if (dot_at_cap) begin
         send_item(OP_BYTE, SEPARATORS[$urandom_range(0, SEPARATORS.len() - 1)]);
         send_item(OP_BYTE, pick_alnum());
      end
      repeat (3) send_item(OP_BYTE, pick_byte());
      send_item(OP_END, 8'($urandom_range(0, 255)));
   endtask

   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.op        <= OP_BYTE;
      req_ch.text_byte <= '0;
      item_spelled     <= 1'b0;
      item_want        <= "";
      src_idle_pct      = 0;
      sink_stall_pct   <= 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, both ops, dot collapse, leading and trailing
      // separators, fallback name and terminator.
      foreach (directed[i]) begin
         send_item(directed[i].op, directed[i].data, directed[i].spelled, directed[i].want);
      end
      wait_drained();

      // Random, one idle pattern per phase; the cap is hit in the first one,
      // with the held dot taking the last slot.
      run_phase(0, 0);
      cap_token(1'b1);
      wait_drained();
      run_phase(88, 0);
      wait_drained();
      run_phase(0, 88);
      wait_drained();
      run_phase(17, 17);
      wait_drained();

      // Long receiver hold-off while the sender keeps offering: the block
      // fills up and must back-pressure its input.
      src_idle_pct    = 0;
      sink_stall_pct <= 0;
      hold_kick      <= ~hold_kick;
      random_tokens(HOLD_ITEMS);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d request transactions, %0d responses checked, %0d tokens closed,",
               items_in, results_seen, tokens_closed);
      $display("%0d bytes dropped at the length cap, four idle patterns and a hold-off, %0d cycles",
               capped_bytes, cycle_count);
      if (fail_count == 0 && pending_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/tc_pkg.sv
sv/tc_chan_if.sv
sv/tc_decode.sv
sv/tc_emit.sv
sv/token_canonicalizer.sv
dv/token_canonicalizer_test.sv
